[rtl/core/lrs_pkg.sv]
// Shared types, constants and the control program of the 8 kHz resampler.
// Used by the sequencer, the datapath, the total divider and the top level.
package lrs_pkg;

   // Resampling constants
   localparam int unsigned TargetRate  = 8000;
   localparam int unsigned RateMin     = 4000;
   localparam int unsigned RateMax     = 48000;
   localparam int unsigned MaxResults  = 5;
   // floor(x / 125) == (x * RecipMul) >> RecipShift for x < 2**22
   localparam int unsigned RecipMul    = 4294968;
   localparam int unsigned RecipShift  = 29;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SOURCE_RATE = 2'd0,
      REG_STEREO_MODE = 2'd1,
      REG_FRAME_COUNT = 2'd2
   } reg_index_type;

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP    = 4'd0,
      OP_ACCEPT = 4'd1,
      OP_MIX    = 4'd2,
      OP_SELECT = 4'd3,
      OP_MUL_A  = 4'd4,
      OP_MUL_B  = 4'd5,
      OP_SUM    = 4'd6,
      OP_RECIP  = 4'd7,
      OP_EMIT   = 4'd8,
      OP_COMMIT = 4'd9
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      C_NEVER     = 3'd0,
      C_ALWAYS    = 3'd1,
      C_NO_ITEM   = 3'd2,
      C_IGNORED   = 3'd3,
      C_LOOP_DONE = 3'd4,
      C_OUT_FREE  = 3'd5
   } cond_type;

   typedef logic [3:0] step_type;

   // Program addresses
   localparam step_type STEP_WAIT     = 4'd0;
   localparam step_type STEP_MIX      = 4'd1;
   localparam step_type STEP_TEST     = 4'd2;
   localparam step_type STEP_MUL_A    = 4'd3;
   localparam step_type STEP_MUL_B    = 4'd4;
   localparam step_type STEP_SUM      = 4'd5;
   localparam step_type STEP_RECIP    = 4'd6;
   localparam step_type STEP_EMIT     = 4'd7;
   localparam step_type STEP_OUT_WAIT = 4'd8;
   localparam step_type STEP_COMMIT   = 4'd9;

   typedef struct packed {
      logic     ready;
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic accepted;
      logic ignored;
      logic loop_done;
      logic out_free;
   } status_type;

   // Control store: one word per step
   function automatic uword_type ucode_rom(step_type pc);
      uword_type w;
      unique case (pc)
         STEP_WAIT:     w = '{1'b1, OP_ACCEPT, C_NO_ITEM,   STEP_WAIT};
         STEP_MIX:      w = '{1'b0, OP_MIX,    C_IGNORED,   STEP_WAIT};
         STEP_TEST:     w = '{1'b0, OP_SELECT, C_LOOP_DONE, STEP_COMMIT};
         STEP_MUL_A:    w = '{1'b0, OP_MUL_A,  C_NEVER,     STEP_WAIT};
         STEP_MUL_B:    w = '{1'b0, OP_MUL_B,  C_NEVER,     STEP_WAIT};
         STEP_SUM:      w = '{1'b0, OP_SUM,    C_NEVER,     STEP_WAIT};
         STEP_RECIP:    w = '{1'b0, OP_RECIP,  C_NEVER,     STEP_WAIT};
         STEP_EMIT:     w = '{1'b0, OP_EMIT,   C_OUT_FREE,  STEP_TEST};
         STEP_OUT_WAIT: w = '{1'b0, OP_NOP,    C_ALWAYS,    STEP_EMIT};
         STEP_COMMIT:   w = '{1'b0, OP_COMMIT, C_ALWAYS,    STEP_WAIT};
         default:       w = '{1'b0, OP_NOP,    C_ALWAYS,    STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

[rtl/core/lrs_total_div.sv]
// Restoring divider for the clip's output count, one quotient bit per cycle.
// Depends on lrs_pkg for the target rate.
module lrs_total_div
   import lrs_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [15:0]                 rate_eff,
   input  logic [FRAME_INDEX_BITS-1:0] n_eff,
   output logic                        busy,
   output logic [FRAME_INDEX_BITS+1:0] total
);

   localparam int NumW = FRAME_INDEX_BITS + 15;
   localparam int CntW = $clog2(NumW + 1);
   localparam logic [14:0] TwiceTarget = 15'(2 * TargetRate);

   logic [NumW-1:0] shift_ff, shift_in;
   logic [16:0]     rem_ff, rem_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [NumW-1:0] num_w;
   logic [16:0]     den;
   logic [17:0]     trial;
   logic            ge;

   // Numerator 2*n*8000 + rate, denominator 2*rate
   assign num_w = NumW'(n_eff) * NumW'(TwiceTarget) + NumW'(rate_eff);
   assign den   = {rate_eff, 1'b0};
   assign trial = {rem_ff, shift_ff[NumW-1]};
   assign ge    = trial >= {1'b0, den};

   // Shift in one quotient bit per cycle
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         shift_in = num_w;
         rem_in   = '0;
         cnt_in   = CntW'(NumW);
      end else if (cnt_ff != '0) begin
         shift_in = {shift_ff[NumW-2:0], ge};
         rem_in   = ge ? 17'(trial - {1'b0, den}) : trial[16:0];
         cnt_in   = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign busy  = cnt_ff != '0;
   assign total = shift_ff[FRAME_INDEX_BITS+1:0];

endmodule

[rtl/core/lrs_sequencer.sv]
// Step counter and control store of the resampler.
// Depends on lrs_pkg for the control word format and the program.
module lrs_sequencer
   import lrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output uword_type  ctrl
);

   step_type pc_ff, pc_in;
   logic     take;

   assign ctrl = ucode_rom(pc_ff);

   // Evaluate the jump condition of the current word
   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:     take = 1'b0;
         C_ALWAYS:    take = 1'b1;
         C_NO_ITEM:   take = !status.accepted;
         C_IGNORED:   take = status.ignored;
         C_LOOP_DONE: take = status.loop_done;
         C_OUT_FREE:  take = status.out_free;
         default:     take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[rtl/core/lrs_datapath.sv]
// Datapath of the resampler: downmix, phase tracking, interpolation and
// output register. Driven by control words from lrs_sequencer; uses lrs_pkg.
module lrs_datapath
   import lrs_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  uword_type                   ctrl,
   input  logic                        req_accept,
   input  logic [31:0]                 req_tdata,
   input  logic                        stereo,
   input  logic [15:0]                 rate_eff,
   input  logic [FRAME_INDEX_BITS-1:0] n_eff,
   input  logic [FRAME_INDEX_BITS+1:0] total,
   input  logic                        clip_clear,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic [15:0]                 rsp_tdata,
   output logic                        rsp_tlast,
   output status_type                  status
);

   localparam int FB = FRAME_INDEX_BITS;

   // Clip state
   logic signed [15:0] prev_ff, prev_in;
   logic [FB-1:0]      frames_ff, frames_in;
   logic [FB+1:0]      sent_ff, sent_in;
   logic [FB:0]        whole_ff, whole_in;
   logic [13:0]        residue_ff, residue_in;
   logic [2:0]         count_ff, count_in;
   // Per-item and per-output working registers
   logic signed [15:0] left_ff, right_ff, mono_ff, a_ff, b_ff;
   logic signed [30:0] prod_a_ff, prod_b_ff;
   logic               neg_ff;
   logic [27:0]        mag_ff;
   logic [15:0]        quot_ff;
   // Output register
   logic               out_valid_ff, out_valid_in;
   logic [15:0]        out_data_ff;
   logic               out_last_ff;

   logic signed [16:0] pair_sum;
   logic signed [15:0] mix;
   logic [13:0]        weight_a;
   logic signed [30:0] interp_sum;
   logic [30:0]        interp_abs;
   logic [44:0]        recip_prod;
   logic [17:0]        scaled7;
   logic [14:0]        scaled;
   logic [15:0]        phase_sum;
   logic [2:0]         phase_step;
   logic               behind, last_frame, loop_go, out_free, emit;
   logic [FB+2:0]      sent_next;

   // Downmix, truncating toward zero
   assign pair_sum = 17'(left_ff) + 17'(right_ff);
   assign mix      = stereo ? 16'((pair_sum + 17'(pair_sum[16])) >>> 1) : left_ff;

   // Loop condition for the next output
   assign behind     = whole_ff < {1'b0, frames_ff};
   assign last_frame = frames_ff == n_eff - 1'b1;
   assign loop_go    = (sent_ff < total) && (count_ff < 3'(MaxResults)) &&
                       (behind || (last_frame && whole_ff == {1'b0, frames_ff}));
   assign out_free   = !out_valid_ff || rsp_tready;
   assign emit       = ctrl.op == OP_EMIT && out_free;

   assign status.accepted  = req_accept;
   assign status.ignored   = frames_ff >= n_eff;
   assign status.loop_done = !loop_go;
   assign status.out_free  = out_free;

   // Interpolation arithmetic
   assign weight_a   = 14'(TargetRate) - residue_ff;
   assign interp_sum = prod_a_ff + prod_b_ff;
   assign interp_abs = interp_sum[30] ? 31'(-interp_sum) : interp_sum;
   assign recip_prod = 45'(mag_ff[27:6]) * 45'(RecipMul);
   assign scaled7    = 18'({quot_ff, 3'b000}) - 18'(quot_ff);
   assign scaled     = scaled7[17:3];

   // Advance phase: residue + rate split into whole steps of 8000
   always_comb begin
      phase_sum  = 16'(residue_ff) + rate_eff;
      phase_step = '0;
      for (int j = 1; j <= 6; j++) begin
         if (phase_sum >= 16'(j * TargetRate)) begin
            phase_step = 3'(j);
         end
      end
   end

   assign sent_next = {1'b0, sent_ff} + 1'b1;

   // Clip state next values
   always_comb begin
      prev_in    = prev_ff;
      frames_in  = frames_ff;
      sent_in    = sent_ff;
      whole_in   = whole_ff;
      residue_in = residue_ff;
      count_in   = count_ff;
      if (clip_clear) begin
         prev_in    = '0;
         frames_in  = '0;
         sent_in    = '0;
         whole_in   = '0;
         residue_in = '0;
      end else begin
         if (ctrl.op == OP_MIX) begin
            count_in = '0;
         end
         if (emit) begin
            sent_in    = sent_ff + 1'b1;
            count_in   = count_ff + 1'b1;
            whole_in   = whole_ff + (FB+1)'(phase_step);
            residue_in = 14'(phase_sum - 16'(phase_step) * 16'(TargetRate));
         end
         if (ctrl.op == OP_COMMIT) begin
            prev_in   = mono_ff;
            frames_in = frames_ff + 1'b1;
         end
      end
   end

   // Hold a result until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         frames_ff    <= '0;
         sent_ff      <= '0;
         whole_ff     <= '0;
         residue_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         frames_ff    <= frames_in;
         sent_ff      <= sent_in;
         whole_ff     <= whole_in;
         residue_ff   <= residue_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers, one operation per step
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_ACCEPT && req_accept) begin
         left_ff  <= req_tdata[15:0];
         right_ff <= req_tdata[31:16];
      end
      if (ctrl.op == OP_MIX) begin
         mono_ff <= mix;
      end
      if (ctrl.op == OP_SELECT) begin
         a_ff <= behind ? prev_ff : mono_ff;
         b_ff <= mono_ff;
      end
      if (ctrl.op == OP_MUL_A) begin
         prod_a_ff <= 31'(a_ff * $signed({1'b0, weight_a}));
      end
      if (ctrl.op == OP_MUL_B) begin
         prod_b_ff <= 31'(b_ff * $signed({1'b0, residue_ff}));
      end
      if (ctrl.op == OP_SUM) begin
         neg_ff <= interp_sum[30];
         mag_ff <= 28'(interp_abs) + 28'(TargetRate / 2);
      end
      if (ctrl.op == OP_RECIP) begin
         quot_ff <= recip_prod[RecipShift+15:RecipShift];
      end
      if (emit) begin
         out_data_ff <= neg_ff ? 16'(-{1'b0, scaled}) : {1'b0, scaled};
         out_last_ff <= sent_next == {1'b0, total};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/core/downmix_linear_resampler_to_8k_unit.sv]
// Top level of the downmixing linear resampler to 8 kHz.
// Instantiates lrs_sequencer, lrs_datapath and lrs_total_div; uses lrs_pkg.
//
// Usage:
//   req_* carries one source frame per item (left and right samples).
//   rsp_* carries resampled 8 kHz mono samples; rsp_tlast marks the final
//   sample of the clip. csr_* writes source_rate (0), stereo_mode (1) and
//   frame_count (2); writing frame_count starts a new clip.
//   Each frame yields zero to five samples. The control program accepts the
//   frame, downmixes it, runs select, two multiplies, sum, reciprocal and
//   emit for each output sample, then makes one last test and commits; a
//   frame past the clip goes back to the accept step after the downmix.
//   After reset and after every write of source_rate or frame_count the
//   output count is recomputed by a serial divider, during which
//   req_tready stays low.
//   Reset restores source_rate 8000, mono mode, frame_count 1 and clears
//   the clip state. A stalled receiver holds its result in the output
//   register; the program keeps working on the next output and waits only
//   when it has another result to place.
module downmix_linear_resampler_to_8k_unit
   import lrs_pkg::*;
#(
   parameter int FRAME_INDEX_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // Source frames
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] left_sample, [31:16] right_sample
   // Resampled output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] out_sample
   output logic        rsp_tlast,
   // Configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int FB = FRAME_INDEX_BITS;

   logic [15:0]      source_rate_ff;
   logic             stereo_mode_ff;
   logic [23:0]      frame_count_ff;
   logic             start_ff, start_in;
   logic             clip_clear;
   logic [15:0]      rate_eff;
   logic [FB+23:0]   frame_wide;
   logic [FB-1:0]    n_raw, n_eff;
   logic [FB+1:0]    total;
   logic             div_busy, busy, req_accept;
   uword_type        ctrl;
   status_type       status;

   // Configuration registers
   assign start_in   = csr_we && (csr_addr == REG_SOURCE_RATE ||
                                  csr_addr == REG_FRAME_COUNT);
   assign clip_clear = csr_we && csr_addr == REG_FRAME_COUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_rate_ff <= 16'(TargetRate);
         stereo_mode_ff <= 1'b0;
         frame_count_ff <= 24'd1;
         start_ff       <= 1'b1;
      end else begin
         start_ff <= start_in;
         if (csr_we) begin
            case (csr_addr)
               REG_SOURCE_RATE: source_rate_ff <= csr_wdata[15:0];
               REG_STEREO_MODE: stereo_mode_ff <= csr_wdata[0];
               REG_FRAME_COUNT: frame_count_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Saturate rate, force a zero frame count to one
   assign rate_eff   = (source_rate_ff < 16'(RateMin)) ? 16'(RateMin) :
                       (source_rate_ff > 16'(RateMax)) ? 16'(RateMax) : source_rate_ff;
   assign frame_wide = {{FB{1'b0}}, frame_count_ff};
   assign n_raw      = frame_wide[FB-1:0];
   assign n_eff      = (n_raw == '0) ? FB'(1) : n_raw;

   assign busy       = start_ff || div_busy;
   assign req_tready = ctrl.ready && !busy;
   assign req_accept = req_tvalid && req_tready;

   lrs_total_div #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
   ) u_total_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .rate_eff (rate_eff),
      .n_eff    (n_eff),
      .busy     (div_busy),
      .total    (total)
   );

   lrs_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   lrs_datapath #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_accept (req_accept),
      .req_tdata  (req_tdata),
      .stereo     (stereo_mode_ff),
      .rate_eff   (rate_eff),
      .n_eff      (n_eff),
      .total      (total),
      .clip_clear (clip_clear),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (status)
   );

   // The program leaves the accept step right after taking an item
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("item accepted twice in a row");

   // A new clip recomputes the output count before taking frames
   assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_addr == REG_FRAME_COUNT) |=> (busy && !req_tready))
      else $error("frame accepted before output count was recomputed");

   // Results are placed only from the emit step
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> ($past(ctrl.op) == OP_EMIT))
      else $error("result appeared outside the emit step");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for downmix_linear_resampler_to_8k_unit: streams source frames,
// predicts every 8 kHz output sample and tlast flag, and checks them in order.
// Depends on lrs_pkg for register indexes and resampling constants.
module testbench
   import lrs_pkg::*;
;

   localparam int     ItemTarget = 500;
   localparam int     SettleCycles = 64;
   localparam longint Denom = TargetRate;

   typedef struct {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
   } frame_type;

   typedef struct {
      logic signed [15:0] out_sample;
      logic               last_sample;
   } sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] left_sample, [31:16] right_sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] out_sample
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   frame_type  pending_frames[$];
   sample_type expected_samples[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         send_gap = 0;
   int         recv_gap = 0;
   logic       req_fire = 1'b0;

   // Own copy of the registers and of the clip position
   logic [15:0]        rate_setting = 16'd8000;
   logic               stereo_setting = 1'b0;
   logic [23:0]        clip_setting = 24'd1;
   logic signed [15:0] last_mono = '0;
   logic [23:0]        frames_taken = '0;
   logic [25:0]        samples_sent = '0;
   logic [24:0]        pos_whole = '0;
   logic [13:0]        pos_residue = '0;

   downmix_linear_resampler_to_8k_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Blend two mono frames at residue r, round half away from zero, scale by 7/8
   function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input int unsigned r);
      longint num;
      longint q;
      num = longint'(a) * (Denom - longint'(r)) + longint'(b) * longint'(r);
      if (num >= 0) q = (num + Denom / 2) / Denom;
      else q = -((-num + Denom / 2) / Denom);
      return 16'((q * 7) / 8);
   endfunction

   function automatic int unsigned clip_length();
      return (clip_setting == 0) ? 1 : clip_setting;
   endfunction

   // Work out the output samples that one accepted frame releases
   task automatic predict_frame(input frame_type f);
      int unsigned        rate_eff;
      int unsigned        clip_len;
      int unsigned        step_sum;
      longint unsigned    total;
      logic signed [15:0] mono;
      logic               final_frame;
      int                 count;
      sample_type         s;
      rate_eff = (rate_setting < RateMin) ? RateMin :
                 (rate_setting > RateMax) ? RateMax : rate_setting;
      clip_len = clip_length();
      total = (2 * longint'(clip_len) * TargetRate + rate_eff) / (2 * longint'(rate_eff));
      // drop frames beyond the clip
      if (frames_taken >= clip_len) return;
      mono = stereo_setting ? 16'((int'(f.left_sample) + int'(f.right_sample)) / 2)
                            : f.left_sample;
      final_frame = (frames_taken + 1 == clip_len);
      count = 0;
      while (samples_sent < total && count < MaxResults) begin
         if (pos_whole + 1 <= frames_taken) begin
            s.out_sample = blend(last_mono, mono, pos_residue);
         end else if (final_frame && pos_whole == frames_taken) begin
            s.out_sample = blend(mono, mono, pos_residue);
         end else begin
            break;
         end
         s.last_sample = (samples_sent + 1 == total);
         expected_samples.insert(expected_samples.size(), s);
         count++;
         samples_sent++;
         step_sum = pos_residue + rate_eff;
         pos_whole = pos_whole + 25'(step_sum / TargetRate);
         pos_residue = 14'(step_sum % TargetRate);
      end
      last_mono = mono;
      frames_taken++;
   endtask

   // Take frames at the rising edge and predict their output
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         predict_frame(pending_frames[0]);
         void'(pending_frames.pop_front());
      end
   end

   // Present frames at the falling edge; hold until taken, pause in bursts
   always @(negedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fire)) begin
         next_valid = 1'b0;
         if (send_gap != 0) begin
            send_gap--;
         end else if (pending_frames.size() == 0) begin
            next_valid = 1'b0;
         end else if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 6);
         end else begin
            next_valid = 1'b1;
            req_tdata <= {pending_frames[0].right_sample, pending_frames[0].left_sample};
         end
         req_tvalid <= next_valid;
      end
   end

   // Stall the result side in bursts
   always @(negedge clock) begin
      if (recv_gap != 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
         recv_gap = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each output item with the oldest expectation
   always @(posedge clock) begin
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %0d last %0b",
                                      $signed(rsp_tdata), rsp_tlast));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want.out_sample)
               report_mismatch($sformatf("out_sample %0d, want %0d",
                                         $signed(rsp_tdata), want.out_sample));
            if (rsp_tlast !== want.last_sample)
               report_mismatch($sformatf("last_sample %0b, want %0b",
                                         rsp_tlast, want.last_sample));
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [23:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SOURCE_RATE: rate_setting = value[15:0];
         REG_STEREO_MODE: stereo_setting = value[0];
         REG_FRAME_COUNT: begin
            // new clip: clear position and history
            clip_setting = value;
            last_mono = '0;
            frames_taken = '0;
            samples_sent = '0;
            pos_whole = '0;
            pos_residue = '0;
         end
         default: ;
      endcase
   endtask

   task automatic push_frame(input logic [15:0] left, input logic [15:0] right);
      frame_type f;
      f.left_sample = left;
      f.right_sample = right;
      pending_frames.insert(pending_frames.size(), f);
   endtask

   // Hold off until every frame is taken and every sample has come, then settle
   task automatic drain();
      while (pending_frames.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic int pick_idle();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 30;
         default: return 60;
      endcase
   endfunction

   initial begin
      int          counted;
      int          remaining;
      int          cap;
      int          batch;
      int unsigned rate;
      logic [15:0] left;
      logic [15:0] right;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // Reset settings: one-frame clip, then a frame past its end
      push_frame(16'h7FFF, 16'h8000);
      push_frame(16'h0000, 16'h0000);
      drain();

      // Rate of zero saturates low, zero length acts as one frame, stereo mix
      write_reg(REG_SOURCE_RATE, 24'd0);
      write_reg(REG_STEREO_MODE, 24'd1);
      write_reg(REG_FRAME_COUNT, 24'd0);
      push_frame(16'h8000, 16'h8000);
      push_frame(16'hFFFF, 16'h0000);
      drain();

      // Rate above range saturates high; stereo extremes
      write_reg(REG_SOURCE_RATE, 24'h00FFFF);
      write_reg(REG_FRAME_COUNT, 24'd3);
      push_frame(16'h7FFF, 16'h7FFF);
      push_frame(16'h8000, 16'h7FFF);
      push_frame(16'h0000, 16'hFFFF);
      drain();

      // Mid-clip rate changes: stall on the output count, then catch up five at a time
      write_reg(REG_SOURCE_RATE, 24'd4000);
      write_reg(REG_STEREO_MODE, 24'd0);
      write_reg(REG_FRAME_COUNT, 24'd12);
      push_frame(16'h7FFF, 16'h1234);
      push_frame(16'h8000, 16'h7FFF);
      push_frame(16'h4321, 16'h8000);
      push_frame(16'hC000, 16'hFFFF);
      drain();
      write_reg(REG_SOURCE_RATE, 24'd48000);
      push_frame(16'h1111, 16'h0000);
      push_frame(16'hEEEE, 16'h5555);
      push_frame(16'h7FFE, 16'h0001);
      push_frame(16'h8001, 16'h0002);
      drain();
      write_reg(REG_SOURCE_RATE, 24'd4000);
      push_frame(16'h2000, 16'h0000);
      push_frame(16'hE000, 16'h0000);
      push_frame(16'h7FFF, 16'h0000);
      push_frame(16'h8000, 16'h0000);
      drain();

      // Longest clip
      write_reg(REG_SOURCE_RATE, 24'd44100);
      write_reg(REG_STEREO_MODE, 24'd1);
      write_reg(REG_FRAME_COUNT, 24'hFFFFFF);
      push_frame(16'h7FFF, 16'h8000);
      push_frame(16'h5A5A, 16'hA5A5);
      drain();

      // Random clips, rates and modes; some clips continue under a new rate
      counted = 0;
      while (counted < ItemTarget) begin
         if (counted > ItemTarget * 9 / 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = pick_idle();
            recv_idle_pct = pick_idle();
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
               0: rate = RateMin;
               1: rate = RateMax;
               2: rate = TargetRate;
               3: rate = 11025;
               4: rate = 44100;
               5: rate = 22050;
               6: rate = $urandom_range(RateMin, RateMax);
               default: rate = $urandom_range(0, 16'hFFFF);
            endcase
            write_reg(REG_SOURCE_RATE, 24'(rate));
         end
         if ($urandom_range(0, 1) != 0) write_reg(REG_STEREO_MODE, 24'($urandom_range(0, 1)));
         remaining = clip_length() - frames_taken;
         if (remaining <= 0 || $urandom_range(0, 4) != 0) begin
            write_reg(REG_FRAME_COUNT, 24'($urandom_range(1, 40)));
            remaining = clip_length() - frames_taken;
         end
         cap = (remaining > 40) ? 40 : remaining;
         batch = ($urandom_range(0, 1) != 0) ? cap : $urandom_range(1, cap);
         for (int i = 0; i < batch; i++) begin
            left = 16'($urandom);
            right = 16'($urandom);
            if ($urandom_range(0, 9) == 0) left = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 9) == 0) right = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            push_frame(left, right);
         end
         counted += batch;
         // occasional frames past the end of the clip
         if (batch == remaining && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) push_frame(16'($urandom), 16'($urandom));
         end
         drain();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
